/* sv/npc_pkg.sv */
// Shared types, constants and functions for the nearest palette color core.
`default_nettype none

package npc_pkg;

    localparam int COLOR_W = 8;
    localparam int INDEX_W = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam int WORD_W  = 3 * COLOR_W;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(195075);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic wr_req;
        logic load_query;
        logic scan_en;
        logic scan_first;
        logic scan_last;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_sts;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

`default_nettype wire

/* sv/nearest_palette_color_core.sv */
// Top level of the nearest palette color core: controller plus datapath.
`default_nettype none

// A write (i_func = 0) gives no result; an index at or beyond PALETTE_ENTRIES
// is dropped. A query (i_func = 1) reads the palette memory one entry per
// cycle and returns the closest entry by squared RGB distance, lowest index on
// ties. o_valid pulses for one cycle once the last entry has passed the read,
// distance and compare registers, and o_busy stays high until the cycle after
// that, so a new query is taken only when the last is through; the palette
// memory has a single read port. Results are not held: the receiver must
// take them on the o_valid cycle. The palette reads as black after reset,
// with no clearing pass.
module nearest_palette_color_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic                              i_func,
    input  wire logic [npc_pkg::INDEX_W-1:0]       i_entry_index,
    input  wire logic [npc_pkg::COLOR_W-1:0]       i_red,
    input  wire logic [npc_pkg::COLOR_W-1:0]       i_green,
    input  wire logic [npc_pkg::COLOR_W-1:0]       i_blue,
    output logic                                   o_valid,
    output logic [npc_pkg::INDEX_W-1:0]            o_best_index,
    output logic [npc_pkg::DIST_W-1:0]             o_best_distance
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    npc_pkg::t_dp_cmd cmd;
    npc_pkg::t_dp_sts sts;
    logic [AW-1:0]    rd_addr;

    npc_ctrl #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_func   (i_func),
        .i_sts    (sts),
        .o_busy   (o_busy),
        .o_cmd    (cmd),
        .o_rd_addr(rd_addr)
    );

    npc_dp #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .i_entry_index  (i_entry_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_sts          (sts),
        .o_best_index   (o_best_index),
        .o_best_distance(o_best_distance)
    );

    assign o_valid = sts.done;

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result transfer outside a query");

    a_query_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_func == npc_pkg::FUNC_QUERY)) |=> o_busy)
        else $error("query transfer did not start a scan");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_func == npc_pkg::FUNC_WRITE)) |=> !o_busy && !o_valid)
        else $error("write transfer disturbed the controller");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_best_distance <= npc_pkg::DIST_MAX))
        else $error("distance out of range");

endmodule

`default_nettype wire

/* sv/npc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/npc_ctrl.sv */
// Controller: accepts commands and sequences the palette scan for a query.
`default_nettype none

module npc_ctrl #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic                               i_func,
    input  wire npc_pkg::t_dp_sts                   i_sts,
    output logic                                    o_busy,
    output npc_pkg::t_dp_cmd                        o_cmd,
    output logic [$clog2(PALETTE_ENTRIES)-1:0]      o_rd_addr
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

    npc_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npc_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_rd_addr = r_cnt;
        case (r_state)
            npc_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_func == npc_pkg::FUNC_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_cnt            = '0;
                        n_state          = npc_pkg::ST_SCAN;
                    end else begin
                        o_cmd.wr_req = 1'b1;
                    end
                end
            end
            npc_pkg::ST_SCAN: begin
                o_cmd.scan_en    = 1'b1;
                o_cmd.scan_first = (r_cnt == '0);
                o_cmd.scan_last  = (r_cnt == LAST_ADDR);
                if (r_cnt == LAST_ADDR) begin
                    n_state = npc_pkg::ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            npc_pkg::ST_DRAIN: begin
                if (i_sts.done) begin
                    n_state = npc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != npc_pkg::ST_IDLE);

endmodule

`default_nettype wire

/* sv/npc_dp.sv */
// Datapath: palette store, distance pipeline and running best entry.
`default_nettype none

module npc_dp #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire npc_pkg::t_dp_cmd                      i_cmd,
    input  wire logic [$clog2(PALETTE_ENTRIES)-1:0]    i_rd_addr,
    input  wire logic [npc_pkg::INDEX_W-1:0]           i_entry_index,
    input  wire logic [npc_pkg::COLOR_W-1:0]           i_red,
    input  wire logic [npc_pkg::COLOR_W-1:0]           i_green,
    input  wire logic [npc_pkg::COLOR_W-1:0]           i_blue,
    output npc_pkg::t_dp_sts                           o_sts,
    output logic [npc_pkg::INDEX_W-1:0]                o_best_index,
    output logic [npc_pkg::DIST_W-1:0]                 o_best_distance
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int CW = npc_pkg::COLOR_W;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [npc_pkg::WORD_W-1:0]   ram_q;
    logic [npc_pkg::WORD_W-1:0]   s1_word;
    logic [npc_pkg::DIST_W-1:0]   s1_dist;

    logic [PALETTE_ENTRIES-1:0]   r_live;
    logic [CW-1:0]                r_q_red, r_q_green, r_q_blue;

    logic                         r_s1_vld, r_s1_first, r_s1_last, r_s1_live;
    logic [AW-1:0]                r_s1_idx;

    logic                         r_s2_vld, r_s2_first, r_s2_last;
    logic [AW-1:0]                r_s2_idx;
    logic [npc_pkg::DIST_W-1:0]   r_s2_dist;

    logic [AW-1:0]                r_best_idx;
    logic [npc_pkg::DIST_W-1:0]   r_best_dist;
    logic                         r_done;

    assign wr_en   = i_cmd.wr_req &&
                     ({1'b0, i_entry_index} < (npc_pkg::INDEX_W + 1)'(PALETTE_ENTRIES));
    assign wr_addr = i_entry_index[AW-1:0];

    npc_ram #(
        .WIDTH(npc_pkg::WORD_W),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata({i_blue, i_green, i_red}),
        .i_re   (i_cmd.scan_en),
        .i_raddr(i_rd_addr),
        .o_rdata(ram_q)
    );

    // entries never written read as black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (wr_en) begin
            r_live[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_q_red   <= i_red;
            r_q_green <= i_green;
            r_q_blue  <= i_blue;
        end
    end

    // stage 1: palette read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.scan_en;
        end
        r_s1_first <= i_cmd.scan_first;
        r_s1_last  <= i_cmd.scan_last;
        r_s1_idx   <= i_rd_addr;
        r_s1_live  <= r_live[i_rd_addr];
    end

    assign s1_word = r_s1_live ? ram_q : '0;
    assign s1_dist = npc_pkg::DIST_W'(npc_pkg::sq_diff(s1_word[CW-1:0], r_q_red))
                   + npc_pkg::DIST_W'(npc_pkg::sq_diff(s1_word[2*CW-1:CW], r_q_green))
                   + npc_pkg::DIST_W'(npc_pkg::sq_diff(s1_word[3*CW-1:2*CW], r_q_blue));

    // stage 2: squared distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_idx   <= r_s1_idx;
        r_s2_dist  <= s1_dist;
    end

    // stage 3: strict compare, first entry always taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s2_vld && r_s2_last;
        end
        if (r_s2_vld && (r_s2_first || (r_s2_dist < r_best_dist))) begin
            r_best_dist <= r_s2_dist;
            r_best_idx  <= r_s2_idx;
        end
    end

    assign o_sts.done      = r_done;
    assign o_best_index    = npc_pkg::INDEX_W'(r_best_idx);
    assign o_best_distance = r_best_dist;

endmodule

`default_nettype wire
